FILE: rtl/core/sd_spi_block_reader_defines.svh
// assertion macros for the sd spi block reader
`ifndef SD_SPI_BLOCK_READER_DEFINES_SVH
`define SD_SPI_BLOCK_READER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define SDR_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("sdr assertion failed");

// condition must never be seen at a clock edge outside reset
`define SDR_ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("sdr forbidden condition seen");

`else

`define SDR_ASSERT(label, clk, rst_n, prop)
`define SDR_ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

FILE: rtl/core/sdr_pkg.sv
// shared types, constants and crc function of the sd spi block reader
package sdr_pkg;

	localparam int SECTOR_BYTES = 512;
	localparam int MAX_SECTORS  = 1024;
	localparam int SECT_CNT_W   = $clog2(SECTOR_BYTES);

	localparam int SECTORS_W = 11;
	localparam int TIMEOUT_W = 10;
	localparam int OFFSET_W  = 19;
	localparam int STATUS_W  = 3;
	localparam int CFG_IDX_W = 1;

	localparam logic [7:0] START_TOKEN = 8'hFE;

	// status codes
	localparam logic [STATUS_W-1:0] ST_IDLE      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_SECTOR_OK = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DONE      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_REJECT    = 3'd4;
	localparam logic [STATUS_W-1:0] ST_CRC_ERR   = 3'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SECTORS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'd1;

	localparam logic [SECTORS_W-1:0] SECTORS_RESET = 11'd1024;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 10'd1000;

	typedef struct packed {
		logic       command;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic                data_valid;
		logic [7:0]          data_byte;
		logic [OFFSET_W-1:0] byte_offset;
		logic [STATUS_W-1:0] status;
	} result_t;

	// one byte of crc16-ccitt, poly 0x1021, msb first
	function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
		logic [15:0] c;
		c = {c_in[7:0], c_in[15:8]};
		c = c ^ {8'h00, b};
		c = c ^ {12'h000, c[7:4]};
		c = c ^ {c[3:0], 12'h000};
		c = c ^ {3'b000, c[7:0], 5'b00000};
		return c;
	endfunction

endpackage

FILE: rtl/core/sdr_engine.sv
// read protocol state and per-byte result logic of the sd spi block reader
module sdr_engine (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  sdr_pkg::item_t                    item,
	input  logic [sdr_pkg::SECTORS_W-1:0]     sectors_to_read,
	input  logic [sdr_pkg::TIMEOUT_W-1:0]     response_timeout,
	output sdr_pkg::result_t                  result
);

	typedef enum logic [5:0] {
		PH_IDLE       = 6'b000001,
		PH_WAIT_R1    = 6'b000010,
		PH_WAIT_TOKEN = 6'b000100,
		PH_DATA       = 6'b001000,
		PH_CRC_HI     = 6'b010000,
		PH_CRC_LO     = 6'b100000
	} phase_t;

	phase_t                             phase_q, phase_d;
	logic [sdr_pkg::TIMEOUT_W-1:0]      poll_q, poll_d;
	logic [sdr_pkg::SECT_CNT_W-1:0]     byte_cnt_q, byte_cnt_d;
	logic [15:0]                        crc_q, crc_d;
	logic [7:0]                         crc_hi_q, crc_hi_d;
	logic [sdr_pkg::SECTORS_W-1:0]      sectors_left_q, sectors_left_d;
	logic [sdr_pkg::OFFSET_W-1:0]       addr_q, addr_d;

	logic [sdr_pkg::SECTORS_W-1:0]      sectors_clamped;
	logic [sdr_pkg::TIMEOUT_W-1:0]      poll_inc;
	logic [sdr_pkg::TIMEOUT_W-1:0]      poll_limit;
	logic [sdr_pkg::SECTORS_W-1:0]      sectors_dec;

	// sector count clamped into 1..MAX_SECTORS
	always_comb begin
		priority if (sectors_to_read == '0) begin
			sectors_clamped = sdr_pkg::SECTORS_W'(1);
		end else if (sectors_to_read > sdr_pkg::SECTORS_W'(sdr_pkg::MAX_SECTORS)) begin
			sectors_clamped = sdr_pkg::SECTORS_W'(sdr_pkg::MAX_SECTORS);
		end else begin
			sectors_clamped = sectors_to_read;
		end
	end

	assign poll_inc    = poll_q + 1'b1;
	assign poll_limit  = (response_timeout == '0) ? sdr_pkg::TIMEOUT_W'(1) : response_timeout;
	assign sectors_dec = (sectors_left_q != '0) ? sectors_left_q - 1'b1 : sectors_left_q;

	// next state and result for the byte in the input register
	always_comb begin
		phase_d        = phase_q;
		poll_d         = poll_q;
		byte_cnt_d     = byte_cnt_q;
		crc_d          = crc_q;
		crc_hi_d       = crc_hi_q;
		sectors_left_d = sectors_left_q;
		addr_d         = addr_q;
		result         = '0;
		result.status  = sdr_pkg::ST_IDLE;

		if (item.command) begin
			sectors_left_d = sectors_clamped;
			phase_d        = PH_WAIT_R1;
			poll_d         = '0;
			byte_cnt_d     = '0;
			crc_d          = '0;
			crc_hi_d       = '0;
			addr_d         = '0;
			result.status  = sdr_pkg::ST_BUSY;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					result.status = sdr_pkg::ST_IDLE;
				end
				PH_WAIT_R1: begin
					result.status = sdr_pkg::ST_BUSY;
					if (!item.rx_byte[7]) begin
						if (item.rx_byte == 8'h00) begin
							phase_d = PH_WAIT_TOKEN;
						end else begin
							phase_d       = PH_IDLE;
							result.status = sdr_pkg::ST_REJECT;
						end
					end else begin
						poll_d = poll_inc;
						if (poll_inc >= poll_limit) begin
							phase_d       = PH_IDLE;
							result.status = sdr_pkg::ST_REJECT;
						end
					end
				end
				PH_WAIT_TOKEN: begin
					result.status = sdr_pkg::ST_BUSY;
					if (item.rx_byte == sdr_pkg::START_TOKEN) begin
						phase_d    = PH_DATA;
						byte_cnt_d = '0;
						crc_d      = '0;
					end
				end
				PH_DATA: begin
					result.status      = sdr_pkg::ST_BUSY;
					result.data_valid  = 1'b1;
					result.data_byte   = item.rx_byte;
					result.byte_offset = addr_q;
					crc_d              = sdr_pkg::crc_byte(crc_q, item.rx_byte);
					addr_d             = addr_q + 1'b1;
					byte_cnt_d         = byte_cnt_q + 1'b1;
					if (byte_cnt_q == sdr_pkg::SECT_CNT_W'(sdr_pkg::SECTOR_BYTES - 1)) begin
						byte_cnt_d = '0;
						phase_d    = PH_CRC_HI;
					end
				end
				PH_CRC_HI: begin
					result.status = sdr_pkg::ST_BUSY;
					crc_hi_d      = item.rx_byte;
					phase_d       = PH_CRC_LO;
				end
				PH_CRC_LO: begin
					if ({crc_hi_q, item.rx_byte} != crc_q) begin
						phase_d       = PH_IDLE;
						result.status = sdr_pkg::ST_CRC_ERR;
					end else begin
						sectors_left_d = sectors_dec;
						if (sectors_dec == '0) begin
							phase_d       = PH_IDLE;
							result.status = sdr_pkg::ST_DONE;
						end else begin
							phase_d       = PH_WAIT_TOKEN;
							result.status = sdr_pkg::ST_SECTOR_OK;
						end
					end
				end
				default: begin
					phase_d       = PH_IDLE;
					result.status = sdr_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// protocol state, updated once per transfer that leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			poll_q         <= '0;
			byte_cnt_q     <= '0;
			crc_q          <= '0;
			crc_hi_q       <= '0;
			sectors_left_q <= '0;
			addr_q         <= '0;
		end else if (step) begin
			phase_q        <= phase_d;
			poll_q         <= poll_d;
			byte_cnt_q     <= byte_cnt_d;
			crc_q          <= crc_d;
			crc_hi_q       <= crc_hi_d;
			sectors_left_q <= sectors_left_d;
			addr_q         <= addr_d;
		end
	end

endmodule

FILE: rtl/core/sd_spi_block_reader.sv
// top level of the sd spi multiple-block read receiver
//
// input channel: in_valid / in_stall carry one item per transfer, either a
// start command (command = 1) or a byte received from the card (rx_byte).
// output channel: out_valid / out_stall carry exactly one result per input
// item: data_valid, data_byte, byte_offset and status.
// configuration: cfg_valid / cfg_ready write cfg_data into register
// cfg_index (0 = sectors_to_read, 1 = response_timeout); cfg_ready is
// always high and writes take effect on the next cycle.
// order: an accepted item is held in the input register, and its result
// is loaded into the output register once that register can advance;
// out_valid rises with that load.
// throughput: one item per cycle unless out_stall holds a result; the input
// register feeds single-pass protocol logic straight into the output register.
// stall: while out_stall holds a result, the input register keeps its item
// and in_stall rises once it is full; nothing is dropped or reordered.
// reset: arst_n clears both pipeline stages, returns the reader to idle
// and loads the register defaults (1024 sectors, timeout 1000 bytes).
`include "sd_spi_block_reader_defines.svh"

module sd_spi_block_reader (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               command,
	input  logic [7:0]                         rx_byte,

	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               data_valid,
	output logic [7:0]                         data_byte,
	output logic [sdr_pkg::OFFSET_W-1:0]       byte_offset,
	output logic [sdr_pkg::STATUS_W-1:0]       status,

	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [sdr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sdr_pkg::SECTORS_W-1:0]      cfg_data
);

	logic [sdr_pkg::SECTORS_W-1:0] sectors_q;
	logic [sdr_pkg::TIMEOUT_W-1:0] timeout_q;

	logic              valid_s1;
	sdr_pkg::item_t    item_s1;
	logic              out_valid_q;
	sdr_pkg::result_t  result_q;
	sdr_pkg::result_t  result_d;
	logic              advance;
	logic              in_take;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sectors_q <= sdr_pkg::SECTORS_RESET;
			timeout_q <= sdr_pkg::TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sdr_pkg::REG_SECTORS: sectors_q <= cfg_data;
				sdr_pkg::REG_TIMEOUT: timeout_q <= cfg_data[sdr_pkg::TIMEOUT_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline flow control
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.command <= command;
			item_s1.rx_byte <= rx_byte;
		end
	end

	// protocol logic
	sdr_engine u_engine (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (valid_s1 && advance),
		.item             (item_s1),
		.sectors_to_read  (sectors_q),
		.response_timeout (timeout_q),
		.result           (result_d)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_q <= result_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign data_valid  = result_q.data_valid;
	assign data_byte   = result_q.data_byte;
	assign byte_offset = result_q.byte_offset;
	assign status      = result_q.status;

	// a payload byte only ever comes with busy status
	`SDR_ASSERT_NEVER(a_data_not_busy, clk, arst_n,
		out_valid_q && result_q.data_valid && result_q.status != sdr_pkg::ST_BUSY)
	// status codes stay within the defined set
	`SDR_ASSERT_NEVER(a_status_range, clk, arst_n,
		out_valid_q && result_q.status > sdr_pkg::ST_CRC_ERR)
	// stall toward the source only when the input register holds an item
	`SDR_ASSERT_NEVER(a_stall_empty, clk, arst_n, in_stall && !valid_s1)
	// a start command always answers busy with no payload
	`SDR_ASSERT(a_start_busy, clk, arst_n,
		(valid_s1 && advance && item_s1.command) |=>
		(out_valid_q && result_q.status == sdr_pkg::ST_BUSY && !result_q.data_valid))

endmodule
